FILE: rtl/text_console_writer_defines.svh
// Assertion macros shared by the text console writer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Plain property checked on every clock edge outside reset.
`define TCW_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Trigger in one cycle implies the consequence in the next cycle.
`define TCW_CHECK_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; used by the engine, the screen memory and the top level.
package tcw_pkg;

    localparam int ROWS_DEFAULT = 25;
    localparam int COLS_DEFAULT = 80;
    localparam int CELL_W       = 16;

    localparam logic [7:0] SPACE_CHAR    = 8'd32;
    localparam logic [7:0] NEWLINE_CHAR  = 8'd10;
    localparam logic [7:0] COLOR_RESET   = 8'd151;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [6:0]        cursor_col;
        logic [4:0]        cursor_row;
        logic [CELL_W-1:0] cell_data;
    } res_t;

endpackage

FILE: rtl/tcw_screen_ram.sv
// Screen cell memory: one write port, one read port with registered data.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram #(
    parameter int DEPTH = tcw_pkg::ROWS_DEFAULT * tcw_pkg::COLS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read, so a result can pick it up late.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tcw_engine.sv
// Command sequencer: cursor tracking, scroll copy and blank fill over the screen memory.
// Depends on tcw_pkg; drives the ports of tcw_screen_ram.
module tcw_engine #(
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int COLS = tcw_pkg::COLS_DEFAULT,
    parameter int AW   = $clog2(ROWS * COLS)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tcw_pkg::cmd_t              cmd,
    output logic                       res_valid,
    input  logic                       res_ready,
    output tcw_pkg::res_t              res,
    input  logic [7:0]                 default_color,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int COPY_N = (ROWS - 1) * COLS;
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_COPY = 2'd2;
    localparam logic [1:0] ST_FILL = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] row_start_reg, row_start_next;
    logic [AW-1:0] cur_addr_reg, cur_addr_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]    fill_color_reg, fill_color_next;
    logic          emit_reg, emit_next;
    logic          is_read_reg, is_read_next;
    logic          adv_row;

    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        row_start_next  = row_start_reg;
        cur_addr_next   = cur_addr_reg;
        cnt_next        = cnt_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = wr_addr_reg;
        fill_color_next = fill_color_reg;
        emit_next       = emit_reg;
        is_read_next    = is_read_reg;
        adv_row         = 1'b0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cur_addr_reg;
        ram_wdata       = {cmd.color, cmd.char_code};
        ram_re          = 1'b0;
        ram_raddr       = AW'(cmd.cell_index);

        // A copied cell lands in the cycle after its read; it owns the write port.
        if (wr_pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    is_read_next = 1'b0;
                    state_next   = ST_EMIT;
                    case (cmd.op)
                        OP_PUT: begin
                            if (cmd.char_code == NEWLINE_CHAR) begin
                                adv_row = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                if (col_reg == CW'(COLS - 1)) begin
                                    adv_row = 1'b1;
                                end else begin
                                    col_next      = col_reg + 1'b1;
                                    cur_addr_next = cur_addr_reg + 1'b1;
                                end
                            end
                            if (adv_row) begin
                                col_next = '0;
                                if (row_reg == RW'(ROWS - 1)) begin
                                    cur_addr_next = row_start_reg;
                                    cnt_next      = '0;
                                    state_next    = ST_COPY;
                                end else begin
                                    row_next       = row_reg + 1'b1;
                                    row_start_next = row_start_reg + AW'(COLS);
                                    cur_addr_next  = row_start_reg + AW'(COLS);
                                end
                            end
                        end
                        OP_READ: begin
                            ram_re       = 1'b1;
                            is_read_next = 32'(cmd.cell_index) < 32'(CELLS);
                        end
                        OP_CLEAR: begin
                            row_next        = '0;
                            col_next        = '0;
                            row_start_next  = '0;
                            cur_addr_next   = '0;
                            cnt_next        = '0;
                            fill_color_next = default_color;
                            emit_next       = 1'b1;
                            state_next      = ST_FILL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COPY: begin
                // Move every row up by one: read a cell one row below, write it back here.
                ram_re       = 1'b1;
                ram_raddr    = cnt_reg + AW'(COLS);
                wr_pend_next = 1'b1;
                wr_addr_next = cnt_reg;
                if (cnt_reg == AW'(COPY_N - 1)) begin
                    cnt_next        = AW'(COPY_N);
                    fill_color_next = default_color;
                    emit_next       = 1'b1;
                    state_next      = ST_FILL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL: begin
                if (!wr_pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg;
                    ram_wdata = {fill_color_reg, SPACE_CHAR};
                    if (cnt_reg == AW'(CELLS - 1)) begin
                        state_next = emit_reg ? ST_EMIT : ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.cell_data  = is_read_reg ? ram_rdata : '0;
    assign res.cursor_row = 5'(row_reg);
    assign res.cursor_col = 7'(col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            row_reg        <= '0;
            col_reg        <= '0;
            row_start_reg  <= '0;
            cur_addr_reg   <= '0;
            cnt_reg        <= '0;
            wr_pend_reg    <= 1'b0;
            fill_color_reg <= COLOR_RESET;
            emit_reg       <= 1'b0;
            is_read_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            row_start_reg  <= row_start_next;
            cur_addr_reg   <= cur_addr_next;
            cnt_reg        <= cnt_next;
            wr_pend_reg    <= wr_pend_next;
            fill_color_reg <= fill_color_next;
            emit_reg       <= emit_next;
            is_read_reg    <= is_read_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= wr_addr_next;
    end

endmodule

FILE: rtl/text_console_writer.sv
// Top level of the text console writer: stream ports, color register, result register.
// Depends on tcw_pkg, tcw_engine, tcw_screen_ram and text_console_writer_defines.svh.

// A ROWS by COLS character console held in one on-chip screen memory of 16-bit cells
// (color in the high byte, character in the low byte) with a hardware cursor. Each
// request on the slave stream is a put (tuser 0), a cell read (tuser 1) or a clear
// (tuser 2), and each gives exactly one result on the master stream carrying the read
// cell (zero for anything but an in-range read) and the cursor after the request.
// Requests are handled one at a time. A printable put, a newline that does not scroll,
// a read and the unused code occupy the engine for the accepting cycle and the step that
// hands the result to the output register, which waits while that register is full; a
// new request is taken only once the result is handed over. A put or newline that
// scrolls occupies it while the screen is copied up one row, one cell per cycle, while
// the last copied cell lands, and while the bottom row is then blanked one cell per
// cycle. A clear occupies it while every cell is blanked in the default color. After
// reset the block runs a clearing pass that blanks the screen in the reset color;
// s_tready stays low until it is done, while the color register can already be written.
// The result register lets the next request enter while a result still waits on m_tready.
`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
    parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // char_code[7:0], color[15:8], cell_index[26:16], zero
    input  logic [1:0]  s_tuser,  // op[1:0]
    input  logic        s_tlast,  // last_in_string
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // cell_data[15:0], cursor_row[20:16], cursor_col[27:21], zero
    // Default color register.
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);

    cmd_t              cmd;
    res_t              res;
    logic              res_valid;
    logic              res_ready;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    logic [7:0]        color_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg;
    logic              last_seen;

    // The string marker carries no meaning for the console; it is only sampled.
    assign last_seen = s_tlast;

    assign cmd.op         = s_tuser;
    assign cmd.char_code  = s_tdata[7:0];
    assign cmd.color      = s_tdata[15:8];
    assign cmd.cell_index = s_tdata[26:16];

    // Default color for blank cells; a change affects only later clears and scrolls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= COLOR_RESET;
        end else if (cfg_wr_en) begin
            color_reg <= cfg_wr_data;
        end
    end

    tcw_engine #(
        .ROWS (ROWS),
        .COLS (COLS),
        .AW   (AW)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .cmd           (cmd),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .default_color (color_reg),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The result register takes a new result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {4'b0, res.cursor_col, res.cursor_row, res.cell_data};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Only one request is in the engine at a time.
    `TCW_CHECK_NEXT(a_one_at_a_time, s_tvalid && s_tready && !last_seen, !s_tready, "request accepted while busy")
    `TCW_CHECK_NEXT(a_one_at_a_time_last, s_tvalid && s_tready && last_seen, !s_tready, "request accepted while busy")
    // The engine never offers a result in the same cycle it can take a request.
    `TCW_CHECK(a_accept_vs_result, !(s_tready && res_valid), "result and request overlap")
    // A presented cursor row always lies on the screen.
    `TCW_CHECK(a_row_in_range, !m_tvalid || (32'(m_tdata[20:16]) < 32'(ROWS)), "cursor row off screen")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for text_console_writer: directed table, then random text traffic.
// Depends on tcw_pkg and the text_console_writer RTL; builds its own mirror of the screen.
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    // The testbench runs the block at its default 80 by 25 geometry.
    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int CELLS = ROWS * COLS;

    // The op code that the block has to ignore.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // A blank cell right after reset: a space in the reset color.
    localparam logic [15:0] BLANK_AT_RESET = {COLOR_RESET, SPACE_CHAR};

    // A scroll or a clear keeps both streams quiet while the screen is copied or blanked, and
    // so does the clearing pass after reset. On top of that come the longest stalls of the sender
    // and the receiver. The limit leaves several times that margin.
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_REQUESTS = 270;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = OP_PUT;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    always #2 aclk = ~aclk;

    text_console_writer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Screen mirror. It holds the cells, the cursor and the blank color as
    // the block should hold them, and is advanced once per accepted request.
    // ------------------------------------------------------------------
    logic [15:0] screen_mirror [CELLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  blank_color;

    // Results still owed by the block, oldest first.
    res_t        owed_results [$];
    // Results typed into the directed table, keyed by request number.
    res_t        typed_results [int];

    int          sent_count     = 0;
    int          accepted_count = 0;
    int          error_count    = 0;
    int          quiet_cycles   = 0;
    int          stall_left     = 0;
    // While set, neither side inserts idle cycles.
    bit          calm           = 1'b0;

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen_mirror[i] = {blank_color, SPACE_CHAR};
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    // Moving below the last row shifts every row up by one and blanks the bottom row.
    function automatic void advance_row();
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
                screen_mirror[i] = screen_mirror[i + COLS];
            end
            for (int i = (ROWS - 1) * COLS; i < CELLS; i++) begin
                screen_mirror[i] = {blank_color, SPACE_CHAR};
            end
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic res_t apply_request(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
                                           logic [10:0] idx);
        res_t r;
        r.cell_data = '0;
        case (op)
            OP_PUT: begin
                if (ch == NEWLINE_CHAR) begin
                    // A newline writes no cell.
                    advance_row();
                    cur_col = 0;
                end else begin
                    screen_mirror[cur_row * COLS + cur_col] = {attr, ch};
                    cur_col++;
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        advance_row();
                    end
                end
            end
            OP_READ: begin
                // Reads past the end of the screen return zero.
                if (idx < CELLS) begin
                    r.cell_data = screen_mirror[idx];
                end
            end
            OP_CLEAR: begin
                blank_screen();
            end
            default: begin
            end
        endcase
        r.cursor_row = 5'(cur_row);
        r.cursor_col = 7'(cur_col);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checker. At each edge it records accepted requests in the mirror and
    // compares every accepted result with the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (aresetn) begin
            // The blank color only changes while no request is in flight.
            if (cfg_wr_en) begin
                blank_color = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[26:16]);
                if (typed_results.exists(accepted_count)) begin
                    want = typed_results[accepted_count];
                end
                owed_results.push_back(want);
                accepted_count++;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[27:0];
                if (owed_results.size() == 0) begin
                    $error("result with no request waiting: m_tdata %h", m_tdata);
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (got.cell_data !== want.cell_data) begin
                        $error("cell_data: expected %h, got %h", want.cell_data, got.cell_data);
                        error_count++;
                    end
                    if (got.cursor_row !== want.cursor_row) begin
                        $error("cursor_row: expected %0d, got %0d",
                               want.cursor_row, got.cursor_row);
                        error_count++;
                    end
                    if (got.cursor_col !== want.cursor_col) begin
                        $error("cursor_col: expected %0d, got %0d",
                               want.cursor_col, got.cursor_col);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then long.
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // The receiver stalls at random, so results back up into the result register.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                stall_left <= gap_len();
            end
        end
    end

    // The watchdog ends a run in which neither stream moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[text_console_writer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Offers one request after a random gap and holds it until the block takes it.
    // tvalid is left high so that back-to-back requests need no second assignment.
    task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                                input logic [7:0] attr, input logic [10:0] idx,
                                input logic last);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, idx, attr, ch};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Drops tvalid and waits until every owed result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_color(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Read addresses: mostly anywhere on screen, some just behind the cursor,
    // some at the corners and some past the end.
    function automatic logic [10:0] pick_index();
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 11'($urandom_range(CELLS, 2047));
        end else if (r < 25) begin
            base = cur_row * COLS + cur_col - $urandom_range(0, 3);
            return 11'((base < 0) ? 0 : base);
        end else if (r < 30) begin
            return ($urandom_range(0, 1) != 0) ? 11'd0 : 11'(CELLS - 1);
        end
        return 11'($urandom_range(0, CELLS - 1));
    endfunction

    // One string call: mostly printable text in a color that changes now and then, with the odd
    // newline and raw byte; some strings are long enough to wrap across rows.
    task automatic send_string();
        int         len;
        int         r;
        logic [7:0] ch;
        logic [7:0] attr;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(1, 24);
        attr = 8'($urandom);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                ch = NEWLINE_CHAR;
            end else if (r < 16) begin
                ch = 8'($urandom);
            end else begin
                ch = 8'($urandom_range(8'h20, 8'h7e));
            end
            if ($urandom_range(0, 7) == 0) begin
                attr = 8'($urandom);
            end
            send_request(OP_PUT, ch, attr, 11'($urandom), k == len - 1);
        end
        if ($urandom_range(0, 1) != 0) begin
            send_request(OP_PUT, NEWLINE_CHAR, 8'($urandom), 11'($urandom), 1'b1);
        end
    endtask

    // Unstructured requests with every field random; clears are kept rare since each
    // one wipes out the cursor progress that the strings built up.
    task automatic send_noise();
        int         r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            op = OP_PUT;
        end else if (r < 75) begin
            op = OP_READ;
        end else if (r < 92) begin
            op = OP_SPARE;
        end else begin
            op = OP_CLEAR;
        end
        send_request(op, 8'($urandom), 8'($urandom), 11'($urandom), 1'($urandom));
    endtask

    // Directed table. Rows with a typed result carry values that are plain from the
    // behavior; the other rows are checked against the mirror.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [10:0] idx;
        logic        last;
        logic        typed;
        logic [15:0] data;
        logic [4:0]  row;
        logic [6:0]  col;
    } script_row_t;

    localparam int SCRIPT_LEN = 19;
    script_row_t script [SCRIPT_LEN];

    initial begin
        int         r;
        int         phase_end;
        logic [7:0] color;

        blank_color = COLOR_RESET;
        blank_screen();

        script = '{
            // The screen comes out of reset blank in the reset color.
            '{OP_READ,  8'h00, 8'h00, 11'd0,    1'b0, 1'b1, BLANK_AT_RESET, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd1999, 1'b0, 1'b1, BLANK_AT_RESET, 5'd0, 7'd0},
            // Reads past the last cell return zero.
            '{OP_READ,  8'hff, 8'hff, 11'd2047, 1'b1, 1'b1, 16'h0000, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd2000, 1'b0, 1'b1, 16'h0000, 5'd0, 7'd0},
            // The unused op code changes nothing.
            '{OP_SPARE, 8'hff, 8'hff, 11'd2047, 1'b1, 1'b1, 16'h0000, 5'd0, 7'd0},
            '{OP_PUT,   8'h41, 8'hff, 11'd0,    1'b0, 1'b1, 16'h0000, 5'd0, 7'd1},
            // Non-printable bytes are stored as they are.
            '{OP_PUT,   8'hff, 8'h00, 11'd2047, 1'b1, 1'b0, 16'h0000, 5'd0, 7'd0},
            '{OP_PUT,   8'h00, 8'h5a, 11'd0,    1'b0, 1'b0, 16'h0000, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd0,    1'b0, 1'b0, 16'h0000, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd1,    1'b0, 1'b0, 16'h0000, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd2,    1'b0, 1'b0, 16'h0000, 5'd0, 7'd0},
            // A newline moves the cursor without writing the cell under it.
            '{OP_PUT,   NEWLINE_CHAR, 8'hab, 11'd0, 1'b1, 1'b0, 16'h0000, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd3,    1'b0, 1'b0, 16'h0000, 5'd0, 7'd0},
            '{OP_PUT,   8'h7e, 8'h81, 11'd0,    1'b0, 1'b0, 16'h0000, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd80,   1'b0, 1'b0, 16'h0000, 5'd0, 7'd0},
            // A clear homes the cursor and blanks every cell.
            '{OP_CLEAR, 8'hff, 8'hff, 11'd2047, 1'b1, 1'b1, 16'h0000, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd0,    1'b0, 1'b1, BLANK_AT_RESET, 5'd0, 7'd0},
            '{OP_READ,  8'h00, 8'h00, 11'd80,   1'b0, 1'b1, BLANK_AT_RESET, 5'd0, 7'd0},
            '{OP_PUT,   NEWLINE_CHAR, 8'h00, 11'd0, 1'b0, 1'b0, 16'h0000, 5'd0, 7'd0}
        };

        // Synchronous reset, released once at the start and never asserted again.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].typed) begin
                typed_results[sent_count] = '{cursor_col: script[i].col,
                                              cursor_row: script[i].row,
                                              cell_data:  script[i].data};
            end
            send_request(script[i].op, script[i].ch, script[i].attr, script[i].idx,
                         script[i].last);
        end

        // Random phases, each under its own blank color. The color is only written
        // once the block has returned every result, so it is idle. A new color does
        // not repaint the screen; later reads show old and new blanks side by side.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_idle();
            if (p == 0) begin
                color = 8'h00;
            end else if (p == 1) begin
                color = 8'hff;
            end else begin
                color = 8'($urandom);
            end
            write_color(color);
            calm      = (p == 2);
            phase_end = sent_count + PHASE_REQUESTS;
            while (sent_count < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_string();
                end else if (r < 80) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_request(OP_READ, 8'($urandom), 8'($urandom), pick_index(),
                                     1'($urandom));
                    end
                end else if (r < 97) begin
                    send_noise();
                end else begin
                    send_request(OP_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom),
                                 1'($urandom));
                end
            end
        end

        // Let the last results come back, then watch a little longer for strays.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("[text_console_writer] OK");
        end else begin
            $display("[text_console_writer] ERROR");
        end
        $finish;
    end

endmodule

FILE: text_console_writer.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/tcw_engine.sv
rtl/text_console_writer.sv
dv/tb_top.sv
